// ===== rtl/fqlp_pkg.sv =====
`default_nettype none

package fqlp_pkg;

   localparam int unsigned BYTE_WIDTH   = 8;
   localparam int unsigned STATUS_WIDTH = 3;
   localparam int unsigned LENGTH_WIDTH = 6;

   typedef enum logic [STATUS_WIDTH-1:0] {
      STATUS_CONT     = 3'd0,
      STATUS_DONE     = 3'd1,
      STATUS_BAD_OPT  = 3'd2,
      STATUS_CR_NO_LF = 3'd3,
      STATUS_EARLY_LF = 3'd4,
      STATUS_EOF      = 3'd5
   } status_type;

   typedef enum logic [2:0] {
      PHASE_NORMAL = 3'b001,
      PHASE_SLASH  = 3'b010,
      PHASE_CR     = 3'b100
   } phase_type;

   localparam logic [BYTE_WIDTH-1:0] CHAR_UNDERSCORE = 8'h5F;
   localparam logic [BYTE_WIDTH-1:0] CHAR_DOT        = 8'h2E;
   localparam logic [BYTE_WIDTH-1:0] CHAR_DASH       = 8'h2D;
   localparam logic [BYTE_WIDTH-1:0] CHAR_AT         = 8'h40;
   localparam logic [BYTE_WIDTH-1:0] CHAR_SLASH      = 8'h2F;
   localparam logic [BYTE_WIDTH-1:0] CHAR_UPPER_W    = 8'h57;
   localparam logic [BYTE_WIDTH-1:0] CHAR_LOWER_W    = 8'h77;
   localparam logic [BYTE_WIDTH-1:0] CHAR_CR         = 8'h0D;
   localparam logic [BYTE_WIDTH-1:0] CHAR_LF         = 8'h0A;
   localparam logic [BYTE_WIDTH-1:0] CHAR_UPPER_A    = 8'h41;
   localparam logic [BYTE_WIDTH-1:0] CHAR_UPPER_Z    = 8'h5A;
   localparam logic [BYTE_WIDTH-1:0] CHAR_LOWER_A    = 8'h61;
   localparam logic [BYTE_WIDTH-1:0] CHAR_LOWER_Z    = 8'h7A;
   localparam logic [BYTE_WIDTH-1:0] CHAR_DIGIT_0    = 8'h30;
   localparam logic [BYTE_WIDTH-1:0] CHAR_DIGIT_9    = 8'h39;

   // Parser state apart from the kept-byte count, whose width follows NAME_MAX.
   typedef struct packed {
      phase_type phase;
      logic      wide_flag;
      logic      forward_flag;
   } flags_type;

   typedef struct packed {
      status_type              status;
      logic [BYTE_WIDTH-1:0]   name_byte;
      logic                    name_byte_valid;
      logic [LENGTH_WIDTH-1:0] name_length;
      logic                    wide_seen;
      logic                    forward_seen;
   } result_type;

endpackage

`default_nettype wire

// ===== rtl/fqlp_if.sv =====
`default_nettype none

interface fqlp_req_if;
   import fqlp_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [BYTE_WIDTH-1:0] byte_in;
   logic                  end_of_input;

   modport source (output valid, output byte_in, output end_of_input, input ready);
   modport sink   (input valid, input byte_in, input end_of_input, output ready);
endinterface

interface fqlp_rsp_if;
   import fqlp_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [STATUS_WIDTH-1:0] status;
   logic [BYTE_WIDTH-1:0]   name_byte;
   logic                    name_byte_valid;
   logic [LENGTH_WIDTH-1:0] name_length;
   logic                    wide_seen;
   logic                    forward_seen;

   modport source (
      output valid, output status, output name_byte, output name_byte_valid,
      output name_length, output wide_seen, output forward_seen, input ready
   );
   modport sink (
      input valid, input status, input name_byte, input name_byte_valid,
      input name_length, input wide_seen, input forward_seen, output ready
   );
endinterface

`default_nettype wire

// ===== rtl/fqlp_step.sv =====
`default_nettype none

module fqlp_step
   import fqlp_pkg::*;
#(
   parameter int unsigned NAME_MAX    = 64,
   parameter int unsigned COUNT_WIDTH = 6
) (
   input  wire logic [BYTE_WIDTH-1:0]  byte_in,
   input  wire logic                   end_of_input,
   input  wire flags_type              flags,
   input  wire logic [COUNT_WIDTH-1:0] count,
   output flags_type                   flags_next,
   output logic [COUNT_WIDTH-1:0]      count_next,
   output result_type                  result
);

   localparam logic [COUNT_WIDTH-1:0] COUNT_LIMIT = COUNT_WIDTH'(NAME_MAX - 1);

   logic                   room;
   logic                   is_name_char;
   logic                   keep;
   status_type             status;
   flags_type              flags_upd;
   logic [COUNT_WIDTH-1:0] count_upd;

   assign room = count < COUNT_LIMIT;

   assign is_name_char = byte_in inside {[CHAR_UPPER_A:CHAR_UPPER_Z],
                                         [CHAR_LOWER_A:CHAR_LOWER_Z],
                                         [CHAR_DIGIT_0:CHAR_DIGIT_9],
                                         CHAR_UNDERSCORE, CHAR_DOT, CHAR_DASH};

   always_comb begin
      status    = STATUS_CONT;
      keep      = 1'b0;
      flags_upd = flags;
      count_upd = count;
      if (end_of_input) begin
         status = STATUS_EOF;
      end else begin
         case (flags.phase)
            PHASE_SLASH: begin
               if (byte_in == CHAR_UPPER_W || byte_in == CHAR_LOWER_W) begin
                  flags_upd.wide_flag = 1'b1;
                  flags_upd.phase     = PHASE_NORMAL;
               end else begin
                  status = STATUS_BAD_OPT;
               end
            end
            PHASE_CR: begin
               status = (byte_in == CHAR_LF) ? STATUS_DONE : STATUS_CR_NO_LF;
            end
            default: begin
               if (is_name_char) begin
                  keep = room;
               end else if (byte_in == CHAR_AT) begin
                  // The forward flag is set even when the byte itself is dropped.
                  flags_upd.forward_flag = 1'b1;
                  keep = room;
               end else if (byte_in == CHAR_SLASH) begin
                  flags_upd.phase = PHASE_SLASH;
               end else if (byte_in == CHAR_CR) begin
                  flags_upd.phase = PHASE_CR;
               end else if (byte_in == CHAR_LF) begin
                  status = STATUS_EARLY_LF;
               end
            end
         endcase
      end
      if (keep) begin
         count_upd = count + COUNT_WIDTH'(1);
      end
   end

   always_comb begin
      result.status          = status;
      result.name_byte       = keep ? byte_in : '0;
      result.name_byte_valid = keep;
      result.name_length     = LENGTH_WIDTH'(count_upd);
      result.wide_seen       = flags_upd.wide_flag;
      result.forward_seen    = flags_upd.forward_flag;
   end

   // Any terminal status starts a new query.
   always_comb begin
      if (status != STATUS_CONT) begin
         flags_next.phase        = PHASE_NORMAL;
         flags_next.wide_flag    = 1'b0;
         flags_next.forward_flag = 1'b0;
         count_next              = '0;
      end else begin
         flags_next = flags_upd;
         count_next = count_upd;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/finger_query_line_parser_core.sv =====
// Channel   Direction  Handshake      Payload
// req_chan  in         valid / ready  byte_in, end_of_input
// rsp_chan  out        valid / ready  status, name_byte, name_byte_valid, name_length,
//                                     wide_seen, forward_seen
//
// One byte is taken every cycle while the result side is not stalled; each byte passes
// through the input register, then the decode and state update into the result register,
// which drives rsp_chan.
// The phase, count and flags are updated as a byte leaves the input register, so the
// next byte always sees them. A stalled result holds its stage and the input register
// behind it; ready falls only when both are full. Synchronous reset clears the valid
// bits and the parser state.
`default_nettype none

module finger_query_line_parser_core
   import fqlp_pkg::*;
#(
   parameter int unsigned NAME_MAX = 64
) (
   input  wire logic   clock,
   input  wire logic   reset,
   fqlp_req_if.sink    req_chan,
   fqlp_rsp_if.source  rsp_chan
);

   localparam int unsigned COUNT_WIDTH = (NAME_MAX > 2) ? $clog2(NAME_MAX) : 1;

   logic                   in_valid_ff;
   logic                   in_valid_in;
   logic [BYTE_WIDTH-1:0]  in_byte_ff;
   logic                   in_eof_ff;

   flags_type              flags_ff;
   flags_type              flags_in;
   flags_type              flags_step;
   logic [COUNT_WIDTH-1:0] count_ff;
   logic [COUNT_WIDTH-1:0] count_in;
   logic [COUNT_WIDTH-1:0] count_step;

   logic                   out_valid_ff;
   logic                   out_valid_in;
   result_type             out_result_ff;
   result_type             step_result;

   logic                   out_free;
   logic                   advance;
   logic                   req_take;

   assign out_free = !out_valid_ff || rsp_chan.ready;
   assign advance  = in_valid_ff && out_free;
   assign req_chan.ready = !in_valid_ff || out_free;
   assign req_take = req_chan.valid && req_chan.ready;

   fqlp_step #(
      .NAME_MAX    (NAME_MAX),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_step (
      .byte_in      (in_byte_ff),
      .end_of_input (in_eof_ff),
      .flags        (flags_ff),
      .count        (count_ff),
      .flags_next   (flags_step),
      .count_next   (count_step),
      .result       (step_result)
   );

   always_comb begin
      in_valid_in  = req_take || (in_valid_ff && !advance);
      out_valid_in = advance || (out_valid_ff && !rsp_chan.ready);
      flags_in     = advance ? flags_step : flags_ff;
      count_in     = advance ? count_step : count_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff            <= 1'b0;
         out_valid_ff           <= 1'b0;
         flags_ff.phase         <= PHASE_NORMAL;
         flags_ff.wide_flag     <= 1'b0;
         flags_ff.forward_flag  <= 1'b0;
         count_ff               <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         flags_ff     <= flags_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_chan.byte_in;
         in_eof_ff  <= req_chan.end_of_input;
      end
      if (advance) begin
         out_result_ff <= step_result;
      end
   end

   assign rsp_chan.valid           = out_valid_ff;
   assign rsp_chan.status          = out_result_ff.status;
   assign rsp_chan.name_byte       = out_result_ff.name_byte;
   assign rsp_chan.name_byte_valid = out_result_ff.name_byte_valid;
   assign rsp_chan.name_length     = out_result_ff.name_length;
   assign rsp_chan.wide_seen       = out_result_ff.wide_seen;
   assign rsp_chan.forward_seen    = out_result_ff.forward_seen;

endmodule

`default_nettype wire

// ===== rtl/fqlp_checker.sv =====
`default_nettype none

module fqlp_checker
   import fqlp_pkg::*;
(
   input wire logic                    clock,
   input wire logic                    reset,
   input wire logic                    rsp_valid,
   input wire logic                    rsp_ready,
   input wire logic [STATUS_WIDTH-1:0] status,
   input wire logic [BYTE_WIDTH-1:0]   name_byte,
   input wire logic                    name_byte_valid,
   input wire logic [LENGTH_WIDTH-1:0] name_length
);

   // A result that waits for the sink keeps its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(name_byte)
         && $stable(name_byte_valid) && $stable(name_length))
      else $error("stalled result changed");

   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // Only a plain continue step can append a byte to the name.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && name_byte_valid |-> status == STATUS_CONT)
      else $error("name byte kept with a terminal status");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !name_byte_valid |-> name_byte == '0)
      else $error("dropped byte not zero");

endmodule

bind finger_query_line_parser_core fqlp_checker u_fqlp_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .status          (rsp_chan.status),
   .name_byte       (rsp_chan.name_byte),
   .name_byte_valid (rsp_chan.name_byte_valid),
   .name_length     (rsp_chan.name_length)
);

`default_nettype wire

// ===== dv/finger_query_line_parser_core_tb.sv =====
`timescale 1ns / 100ps

module finger_query_line_parser_core_tb;
   import fqlp_pkg::*;

   localparam int unsigned NAME_LIMIT   = 64;
   localparam int unsigned RANDOM_BYTES = 400;
   localparam int unsigned LIMIT_CYCLES = 200000;
   localparam int unsigned IDLE_PERCENT = 36;
   localparam int unsigned CALM_FIRST   = 150;
   localparam int unsigned CALM_LAST    = 260;

   typedef struct {
      logic [BYTE_WIDTH-1:0] data;
      logic                  eoi;
      bit                    drain;
   } query_item_type;

   logic clock;
   logic reset;

   fqlp_req_if req_chan();
   fqlp_rsp_if rsp_chan();

   finger_query_line_parser_core #(.NAME_MAX(NAME_LIMIT)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   query_item_type byte_queue[$];
   result_type     parsed_results[$];

   // Local copy of the parser state.
   phase_type   parse_phase  = PHASE_NORMAL;
   int unsigned kept_bytes   = 0;
   logic        wide_flag    = 1'b0;
   logic        forward_flag = 1'b0;

   int unsigned total_items = 0;
   int unsigned sent_count  = 0;
   int unsigned cycle_count = 0;
   int unsigned error_count = 0;
   bit          req_taken   = 1'b0;
   bit          drain_next  = 1'b0;

   wire calm_window = (sent_count >= CALM_FIRST) && (sent_count < CALM_LAST);

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic result_type parse_byte(input logic [BYTE_WIDTH-1:0] c, input logic eoi);
      result_type r;
      logic       room;
      logic       is_name;
      room = kept_bytes < NAME_LIMIT - 1;
      is_name = (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) ||
                (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) ||
                (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) ||
                c == CHAR_UNDERSCORE || c == CHAR_DOT || c == CHAR_DASH;
      r = '0;
      r.status = STATUS_CONT;
      if (eoi) begin
         r.status = STATUS_EOF;
      end else begin
         case (parse_phase)
            PHASE_SLASH: begin
               if (c == CHAR_UPPER_W || c == CHAR_LOWER_W) begin
                  wide_flag = 1'b1;
                  parse_phase = PHASE_NORMAL;
               end else begin
                  r.status = STATUS_BAD_OPT;
               end
            end
            PHASE_CR: begin
               r.status = (c == CHAR_LF) ? STATUS_DONE : STATUS_CR_NO_LF;
            end
            default: begin
               if (is_name || c == CHAR_AT) begin
                  // An '@' raises the forward flag even when the name is full.
                  if (c == CHAR_AT) forward_flag = 1'b1;
                  if (room) begin
                     r.name_byte = c;
                     r.name_byte_valid = 1'b1;
                     kept_bytes++;
                  end
               end else if (c == CHAR_SLASH) begin
                  parse_phase = PHASE_SLASH;
               end else if (c == CHAR_CR) begin
                  parse_phase = PHASE_CR;
               end else if (c == CHAR_LF) begin
                  r.status = STATUS_EARLY_LF;
               end
            end
         endcase
      end
      r.name_length = kept_bytes[LENGTH_WIDTH-1:0];
      r.wide_seen = wide_flag;
      r.forward_seen = forward_flag;
      if (r.status != STATUS_CONT) begin
         parse_phase = PHASE_NORMAL;
         kept_bytes = 0;
         wide_flag = 1'b0;
         forward_flag = 1'b0;
      end
      return r;
   endfunction

   task automatic push_byte(input logic [BYTE_WIDTH-1:0] data, input logic eoi = 1'b0);
      query_item_type item;
      item.data = data;
      item.eoi = eoi;
      item.drain = drain_next;
      drain_next = 1'b0;
      byte_queue.push_back(item);
   endtask

   function automatic logic [BYTE_WIDTH-1:0] random_name_char();
      case ($urandom_range(5, 0))
         0: return 8'(CHAR_UPPER_A + $urandom_range(25, 0));
         1: return 8'(CHAR_LOWER_A + $urandom_range(25, 0));
         2: return 8'(CHAR_DIGIT_0 + $urandom_range(9, 0));
         3: return CHAR_UNDERSCORE;
         4: return CHAR_DOT;
         default: return CHAR_DASH;
      endcase
   endfunction

   task automatic push_query(input bit long_name);
      int unsigned           name_len;
      int unsigned           at_pos;
      int unsigned           ending;
      logic [BYTE_WIDTH-1:0] b;
      name_len = long_name ? $urandom_range(70, 58) : $urandom_range(12, 0);
      at_pos = long_name ? $urandom_range(name_len + 2, 50) : $urandom_range(name_len + 4, 0);
      for (int unsigned i = 0; i < name_len; i++) begin
         if (i == at_pos) push_byte(CHAR_AT);
         else push_byte(random_name_char());
         if ($urandom_range(9, 0) == 0) begin
            push_byte(CHAR_SLASH);
            push_byte($urandom_range(1, 0) ? CHAR_UPPER_W : CHAR_LOWER_W);
         end
         if ($urandom_range(19, 0) == 0) push_byte(8'($urandom_range(255, 0)));
      end
      ending = $urandom_range(99, 0);
      if (ending < 66) begin
         push_byte(CHAR_CR);
         push_byte(CHAR_LF);
      end else if (ending < 72) begin
         push_byte(CHAR_SLASH);
         do b = 8'($urandom_range(255, 0));
         while (b == CHAR_UPPER_W || b == CHAR_LOWER_W);
         push_byte(b);
      end else if (ending < 78) begin
         push_byte(CHAR_CR);
         do b = 8'($urandom_range(255, 0));
         while (b == CHAR_LF);
         push_byte(b);
      end else if (ending < 84) begin
         push_byte(CHAR_LF);
      end else if (ending < 89) begin
         push_byte(8'($urandom_range(255, 0)), 1'b1);
      end else if (ending < 92) begin
         push_byte(CHAR_SLASH);
         push_byte(8'($urandom_range(255, 0)), 1'b1);
      end else if (ending < 95) begin
         push_byte(CHAR_CR);
         push_byte(8'($urandom_range(255, 0)), 1'b1);
      end else begin
         push_byte(8'($urandom_range(255, 0)));
         push_byte(CHAR_CR);
         push_byte(CHAR_LF);
      end
   endtask

   initial begin
      int unsigned directed_count;
      int unsigned line_index;
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.byte_in = '0;
      req_chan.end_of_input = 1'b0;
      rsp_chan.ready = 1'b0;

      // Directed part: every character class, both option cases, every ending.
      push_byte(CHAR_UPPER_A);
      push_byte(CHAR_LOWER_Z);
      push_byte(CHAR_DIGIT_0);
      push_byte(CHAR_DIGIT_9);
      push_byte(CHAR_UNDERSCORE);
      push_byte(CHAR_DOT);
      push_byte(CHAR_DASH);
      push_byte(CHAR_SLASH);
      push_byte(CHAR_UPPER_W);
      push_byte(CHAR_AT);
      push_byte(CHAR_SLASH);
      push_byte(CHAR_LOWER_W);
      push_byte(8'h00);
      push_byte(8'hFF);
      push_byte(CHAR_CR);
      push_byte(CHAR_LF);
      push_byte(CHAR_SLASH);
      push_byte(8'h78);
      push_byte(8'h71);
      push_byte(CHAR_CR);
      push_byte(8'h61);
      push_byte(CHAR_LF);
      push_byte(8'h62);
      push_byte(8'hFF, 1'b1);
      directed_count = byte_queue.size();

      // First random query fills the name past the limit, puts '@' there, then /W and CR LF.
      drain_next = 1'b1;
      for (int unsigned i = 0; i < 66; i++) push_byte(random_name_char());
      push_byte(CHAR_AT);
      push_byte(CHAR_SLASH);
      push_byte(CHAR_UPPER_W);
      push_byte(CHAR_CR);
      push_byte(CHAR_LF);

      line_index = 0;
      while (byte_queue.size() - directed_count < RANDOM_BYTES) begin
         line_index++;
         if (line_index == 12) drain_next = 1'b1;
         if ($urandom_range(14, 0) == 0) begin
            repeat ($urandom_range(8, 1))
               push_byte(8'($urandom_range(255, 0)), $urandom_range(7, 0) == 0);
         end else begin
            push_query($urandom_range(11, 0) == 0);
         end
      end
      total_items = byte_queue.size();

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      while (sent_count < total_items || parsed_results.size() != 0) @(negedge clock);
      repeat (10) @(negedge clock);
      if (parsed_results.size() != 0) begin
         $error("%0d expected results never arrived", parsed_results.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   initial begin
      while (cycle_count < LIMIT_CYCLES) @(negedge clock);
      $display("FAILURE");
      $finish;
   end

   // Driver: a new byte is presented only once the previous one has been transferred.
   always @(negedge clock) begin
      query_item_type item;
      bit             stall;
      if (reset) begin
         req_chan.valid <= 1'b0;
         rsp_chan.ready <= 1'b1;
      end else begin
         rsp_chan.ready <= calm_window || ($urandom_range(99, 0) >= IDLE_PERCENT);
         if (!req_chan.valid || req_taken) begin
            stall = !calm_window && ($urandom_range(99, 0) < IDLE_PERCENT);
            if (byte_queue.size() != 0 && !stall &&
                !(byte_queue[0].drain && parsed_results.size() != 0)) begin
               item = byte_queue.pop_front();
               req_chan.valid <= 1'b1;
               req_chan.byte_in <= item.data;
               req_chan.end_of_input <= item.eoi;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: predicts each transferred byte and checks each transferred result.
   always @(posedge clock) begin
      result_type want;
      cycle_count <= cycle_count + 1;
      if (reset) begin
         req_taken <= 1'b0;
         parse_phase = PHASE_NORMAL;
         kept_bytes = 0;
         wide_flag = 1'b0;
         forward_flag = 1'b0;
      end else begin
         req_taken <= req_chan.valid && req_chan.ready;
         if (req_chan.valid && req_chan.ready) begin
            parsed_results.push_back(parse_byte(req_chan.byte_in, req_chan.end_of_input));
            sent_count++;
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (parsed_results.size() == 0) begin
               $error("result transfer with no byte waiting for one");
               error_count++;
            end else begin
               want = parsed_results.pop_front();
               if (rsp_chan.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_chan.status);
                  error_count++;
               end
               if (rsp_chan.name_byte !== want.name_byte) begin
                  $error("name_byte: expected %0h, got %0h", want.name_byte,
                         rsp_chan.name_byte);
                  error_count++;
               end
               if (rsp_chan.name_byte_valid !== want.name_byte_valid) begin
                  $error("name_byte_valid: expected %0d, got %0d", want.name_byte_valid,
                         rsp_chan.name_byte_valid);
                  error_count++;
               end
               if (rsp_chan.name_length !== want.name_length) begin
                  $error("name_length: expected %0d, got %0d", want.name_length,
                         rsp_chan.name_length);
                  error_count++;
               end
               if (rsp_chan.wide_seen !== want.wide_seen) begin
                  $error("wide_seen: expected %0d, got %0d", want.wide_seen,
                         rsp_chan.wide_seen);
                  error_count++;
               end
               if (rsp_chan.forward_seen !== want.forward_seen) begin
                  $error("forward_seen: expected %0d, got %0d", want.forward_seen,
                         rsp_chan.forward_seen);
                  error_count++;
               end
            end
         end
      end
   end

endmodule

// ===== sim.f =====
rtl/fqlp_pkg.sv
rtl/fqlp_if.sv
rtl/fqlp_step.sv
rtl/finger_query_line_parser_core.sv
rtl/fqlp_checker.sv
dv/finger_query_line_parser_core_tb.sv
